FILE: sv/nnf_pkg.sv
// Shared types and codes for the node navigation controller.
package nnf_pkg;

    typedef enum logic [2:0] {
        NAV_HALT   = 3'd0,
        NAV_FOLLOW = 3'd1,
        NAV_WAIT   = 3'd2,
        NAV_NODE   = 3'd3,
        NAV_TURN   = 3'd4
    } t_nav_state;

    typedef enum logic [1:0] {
        PH_NONE    = 2'd0,
        PH_BLIND   = 2'd1,
        PH_CAPTURE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        TURN_NONE  = 2'd0,
        TURN_LEFT  = 2'd1,
        TURN_RIGHT = 2'd2
    } t_dir;

    // Host command codes.
    localparam logic [2:0] CMD_LEFT     = 3'd0;
    localparam logic [2:0] CMD_RIGHT    = 3'd1;
    localparam logic [2:0] CMD_STRAIGHT = 3'd2;
    localparam logic [2:0] CMD_WAIT     = 3'd3;
    localparam logic [2:0] CMD_AUTO     = 3'd4;
    localparam logic [2:0] CMD_STOP     = 3'd5;

    // Word kinds.
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_COOLDOWN = 2'd0;
    localparam logic [1:0] REG_WAIT     = 2'd1;
    localparam logic [1:0] REG_BLIND    = 2'd2;
    localparam logic [1:0] REG_TIMEOUT  = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] COOLDOWN_RST = 16'd500;
    localparam logic        WAIT_RST     = 1'b1;
    localparam logic [15:0] BLIND_RST    = 16'd300;
    localparam logic [15:0] TIMEOUT_RST  = 16'd1500;

    typedef struct packed {
        logic [15:0] cooldown_ms;
        logic        wait_for_host;
        logic [15:0] blind_ms;
        logic [15:0] timeout_ms;
    } t_cfg;

    typedef struct packed {
        t_nav_state  state;
        t_phase      phase;
        t_dir        dir;
        logic        auto_mode;
        logic [31:0] last_node_time;
        logic [31:0] turn_start_time;
    } t_nav_regs;

    typedef struct packed {
        logic node_reached;
        logic turn_captured;
        logic turn_timed_out;
    } t_events;

endpackage

FILE: sv/nnf_step.sv
// Next-state and event logic for one navigation word.
module nnf_step (
    input  nnf_pkg::t_nav_regs i_cur,
    input  nnf_pkg::t_cfg      i_cfg,
    input  logic               i_kind,
    input  logic               i_node_detected,
    input  logic               i_line_detected,
    input  logic [31:0]        i_time_ms,
    input  logic [2:0]         i_command,
    output nnf_pkg::t_nav_regs o_nxt,
    output nnf_pkg::t_events   o_evt
);
    import nnf_pkg::*;

    logic [31:0] node_gap;
    logic [31:0] elapsed;

    assign node_gap = i_time_ms - i_cur.last_node_time;
    assign elapsed  = i_time_ms - i_cur.turn_start_time;

    always_comb begin
        o_nxt = i_cur;
        o_evt = '0;
        if (i_kind == KIND_COMMAND) begin
            case (i_command)
                CMD_LEFT, CMD_RIGHT: begin
                    o_nxt.state           = NAV_TURN;
                    o_nxt.phase           = PH_BLIND;
                    o_nxt.dir             = (i_command == CMD_LEFT) ? TURN_LEFT : TURN_RIGHT;
                    o_nxt.turn_start_time = i_time_ms;
                end
                CMD_STRAIGHT: o_nxt.state = NAV_FOLLOW;
                CMD_WAIT:     o_nxt.state = NAV_WAIT;
                CMD_AUTO: begin
                    o_nxt.auto_mode = 1'b1;
                    o_nxt.state     = NAV_FOLLOW;
                end
                CMD_STOP: begin
                    o_nxt.state     = NAV_HALT;
                    o_nxt.auto_mode = 1'b0;
                end
                default: ;
            endcase
        end else if (i_cur.state == NAV_FOLLOW) begin
            // Node arrival is only taken while following, after the cooldown.
            if (i_node_detected && (node_gap > {16'd0, i_cfg.cooldown_ms})) begin
                o_nxt.last_node_time = i_time_ms;
                o_evt.node_reached   = 1'b1;
                if (i_cfg.wait_for_host) begin
                    o_nxt.state = NAV_WAIT;
                end else if (i_cur.auto_mode) begin
                    o_nxt.state = NAV_FOLLOW;
                end else begin
                    o_nxt.state = NAV_NODE;
                end
            end
        end else if (i_cur.state == NAV_TURN) begin
            case (i_cur.phase)
                PH_BLIND: begin
                    if (elapsed > {16'd0, i_cfg.blind_ms}) begin
                        o_nxt.phase = PH_CAPTURE;
                    end
                end
                PH_CAPTURE: begin
                    if (i_line_detected) begin
                        o_evt.turn_captured = 1'b1;
                    end
                    if (elapsed > {16'd0, i_cfg.timeout_ms}) begin
                        o_evt.turn_timed_out = 1'b1;
                    end
                    if (i_line_detected || (elapsed > {16'd0, i_cfg.timeout_ms})) begin
                        o_nxt.state = NAV_FOLLOW;
                        o_nxt.phase = PH_NONE;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: sv/node_navigation_fsm_core.sv
// Top level of the node navigation controller: handshakes, registers, config port.
// A result word is registered and appears on the output in the cycle after its input word is accepted.
// Throughput: one word per cycle unless the output stalls; the next state is one short pass of
// compare logic (two 32-bit wrapping subtracts and compares) from state to result registers.
// Reset: synchronous, active low; navigation state returns to idle with no turn and no
// direction, timers clear to zero, and the configuration registers take their defaults.
module node_navigation_fsm_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input word channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic        i_node_detected,
    input  logic        i_line_detected,
    input  logic [31:0] i_time_ms,
    input  logic [2:0]  i_command,
    // Result word channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_nav_state,
    output logic [1:0]  o_turn_phase,
    output logic [1:0]  o_turn_direction,
    output logic        o_autonomous,
    output logic        o_node_reached,
    output logic        o_turn_captured,
    output logic        o_turn_timed_out,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nnf_pkg::*;

    // Navigation state, configuration and the result register.
    t_nav_regs r_nav;
    t_nav_regs n_nav;
    t_cfg      r_cfg;
    t_events   n_evt;

    logic       r_out_valid;
    t_nav_regs  r_out_nav;
    t_events    r_out_evt;

    logic       in_take;
    logic       cfg_write;
    logic [1:0] cfg_index;

    // A new word is taken whenever the result register is empty or drains this cycle,
    // so the two sides never stall each other beyond a single full slot.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_take    = i_in_valid && o_in_ready;

    nnf_step u_step (
        .i_cur           (r_nav),
        .i_cfg           (r_cfg),
        .i_kind          (i_kind),
        .i_node_detected (i_node_detected),
        .i_line_detected (i_line_detected),
        .i_time_ms       (i_time_ms),
        .i_command       (i_command),
        .o_nxt           (n_nav),
        .o_evt           (n_evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nav.state           <= NAV_HALT;
            r_nav.phase           <= PH_NONE;
            r_nav.dir             <= TURN_NONE;
            r_nav.auto_mode       <= 1'b0;
            r_nav.last_node_time  <= '0;
            r_nav.turn_start_time <= '0;
        end else if (in_take) begin
            r_nav <= n_nav;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The result payload needs no reset; it is only looked at while valid.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out_nav <= n_nav;
            r_out_evt <= n_evt;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_nav_state      = r_out_nav.state;
    assign o_turn_phase     = r_out_nav.phase;
    assign o_turn_direction = r_out_nav.dir;
    assign o_autonomous     = r_out_nav.auto_mode;
    assign o_node_reached   = r_out_evt.node_reached;
    assign o_turn_captured  = r_out_evt.turn_captured;
    assign o_turn_timed_out = r_out_evt.turn_timed_out;

    // Configuration registers sit at word addresses; the low two address bits are ignored.
    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cooldown_ms   <= COOLDOWN_RST;
            r_cfg.wait_for_host <= WAIT_RST;
            r_cfg.blind_ms      <= BLIND_RST;
            r_cfg.timeout_ms    <= TIMEOUT_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_COOLDOWN: r_cfg.cooldown_ms   <= pwdata[15:0];
                REG_WAIT:     r_cfg.wait_for_host <= pwdata[0];
                REG_BLIND:    r_cfg.blind_ms      <= pwdata[15:0];
                REG_TIMEOUT:  r_cfg.timeout_ms    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_COOLDOWN: prdata = {16'd0, r_cfg.cooldown_ms};
            REG_WAIT:     prdata = {31'd0, r_cfg.wait_for_host};
            REG_BLIND:    prdata = {16'd0, r_cfg.blind_ms};
            REG_TIMEOUT:  prdata = {16'd0, r_cfg.timeout_ms};
            default:      prdata = '0;
        endcase
    end

    // A turn always carries a live phase; it is cleared only when the turn ends.
    a_turn_has_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nav.state == NAV_TURN) |-> (r_nav.phase != PH_NONE))
        else $error("turning without a turn phase");

    // A captured or timed-out turn always hands back to line following with no phase.
    a_turn_end_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_turn_captured || o_turn_timed_out)) |->
        ((o_nav_state == NAV_FOLLOW) && (o_turn_phase == PH_NONE)))
        else $error("turn ended without returning to follow");

    // A node arrival never lands in the idle or turning state.
    a_node_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_node_reached) |->
        ((o_nav_state == NAV_WAIT) || (o_nav_state == NAV_NODE) ||
         (o_nav_state == NAV_FOLLOW)))
        else $error("node arrival in a wrong state");

    // Every accepted word produces a result on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_out_valid)
        else $error("accepted word produced no result");

endmodule
